// ----- sv/dmslw_pkg.sv -----
package dmslw_pkg;

  localparam int unsigned MotorChannels = 2;
  localparam int unsigned PwmW          = 8;

  localparam logic CH_RIGHT = 1'b0;
  localparam logic CH_LEFT  = 1'b1;

  // function codes carried in tuser
  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_SET  = 2'd1;
  localparam logic [1:0] FUNC_PING = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_SLEW_STEP     = 3'd0;
  localparam logic [2:0] REG_MAX_PWM       = 3'd1;
  localparam logic [2:0] REG_TIMEOUT_TICKS = 3'd2;
  localparam logic [2:0] REG_RIGHT_FWD     = 3'd3;
  localparam logic [2:0] REG_LEFT_FWD      = 3'd4;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 40;

  typedef struct packed {
    logic [PwmW-1:0] pwm;
    logic            dir;
  } motor_t;

  // signed speed to saturated magnitude plus direction bit
  function automatic motor_t speed_to_target(input logic [15:0] speed,
                                             input logic        fwd,
                                             input logic [PwmW-1:0] max_pwm);
    logic [16:0] mag;
    motor_t      res;
    if (speed[15]) begin
      mag     = 17'h10000 - {1'b0, speed};
      res.dir = ~fwd;
    end else begin
      mag     = {1'b0, speed};
      res.dir = fwd;
    end
    if (mag > {9'd0, max_pwm}) begin
      res.pwm = max_pwm;
    end else begin
      res.pwm = mag[PwmW-1:0];
    end
    return res;
  endfunction

  // one slew step of the actual value toward the target
  function automatic motor_t slew(input motor_t act, input motor_t tgt,
                                  input logic [PwmW-1:0] step,
                                  input logic [PwmW-1:0] max_pwm);
    logic [PwmW-1:0] dn;
    logic [PwmW:0]   up;
    motor_t          res;
    dn  = (act.pwm > step) ? act.pwm - step : '0;
    up  = {1'b0, act.pwm} + {1'b0, step};
    res = act;
    if (tgt.dir != act.dir) begin
      res.pwm = dn;
      if (dn == '0) begin
        res.dir = tgt.dir;
      end
    end else if (act.pwm > tgt.pwm) begin
      res.pwm = (dn > max_pwm) ? max_pwm : dn;
      if (res.pwm < tgt.pwm) begin
        res.pwm = tgt.pwm;
      end
    end else if (act.pwm < tgt.pwm) begin
      if (up > {1'b0, max_pwm}) begin
        up = {1'b0, max_pwm};
      end
      if (up > {1'b0, tgt.pwm}) begin
        up = {1'b0, tgt.pwm};
      end
      res.pwm = up[PwmW-1:0];
    end
    return res;
  endfunction

endpackage

// ----- sv/dual_motor_slew_limiter_watchdog.sv -----
// dual h-bridge drive with slew-rate limiting and a communication watchdog
// input stream: tuser carries the function code (tick, set speed, ping),
//   tdata carries speed_right [15:0] and speed_left [31:16], both signed
// output stream: one transaction per input transaction, holding the plus and
//   minus compare values of both bridges and the timeout flag, taken from
//   the motor state after that input
// config channel: cfg_index_i selects slew_step, max_pwm, timeout_ticks,
//   right_forward_dir or left_forward_dir; writes always complete at once,
//   unknown indexes are dropped
// results: each is registered in the output register, or in the skid while the receiver stalls
// throughput: one transaction per cycle while the skid is empty; all state is
//   updated by a single combinational pass between input handshake and result register
// stalls: a result register plus a skid register; while the receiver stalls
//   one more input is taken into the skid, after that s_axis_tready drops
// reset: motors at zero, targets zero, watchdog cleared, registers at their
//   defaults (slew 4, max 255, timeout 10, right fwd 0, left fwd 1)
module dual_motor_slew_limiter_watchdog (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [dmslw_pkg::InDataW-1:0]  s_axis_tdata,  // speed_right, speed_left
  input  logic [1:0]  s_axis_tuser,                      // func
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // left_plus, left_minus, right_plus, right_minus, timeout_active, zero pad
  output logic [dmslw_pkg::OutDataW-1:0] m_axis_tdata
);
  import dmslw_pkg::*;

  // configuration registers
  logic [PwmW-1:0] slew_step_q, max_pwm_q, timeout_ticks_q;
  logic            right_fwd_q, left_fwd_q;

  // motor and watchdog state
  motor_t          actual_q [MotorChannels];
  motor_t          actual_d [MotorChannels];
  motor_t          target_q [MotorChannels];
  motor_t          target_d [MotorChannels];
  logic [PwmW-1:0] count_q, count_d;
  logic            seen_q, seen_d;

  // result and skid registers
  logic                out_valid_q, skid_valid_q;
  logic [OutDataW-1:0] out_data_q, skid_data_q;
  logic [OutDataW-1:0] result;

  logic            in_fire, out_fire;
  logic [PwmW-1:0] count_inc;
  motor_t          fwd_zero [MotorChannels];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = ~skid_valid_q;
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign out_fire      = out_valid_q & m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slew_step_q     <= 8'd4;
      max_pwm_q       <= 8'd255;
      timeout_ticks_q <= 8'd10;
      right_fwd_q     <= 1'b0;
      left_fwd_q      <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SLEW_STEP:     slew_step_q     <= cfg_data_i;
        REG_MAX_PWM:       max_pwm_q       <= cfg_data_i;
        REG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data_i;
        REG_RIGHT_FWD:     right_fwd_q     <= cfg_data_i[0];
        REG_LEFT_FWD:      left_fwd_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // saturating watchdog increment
  assign count_inc = (count_q == '1) ? count_q : count_q + 8'd1;

  // target used when the watchdog first fires: zero speed, forward direction
  assign fwd_zero[CH_RIGHT] = '{pwm: '0, dir: right_fwd_q};
  assign fwd_zero[CH_LEFT]  = '{pwm: '0, dir: left_fwd_q};

  always_comb begin
    actual_d = actual_q;
    target_d = target_q;
    count_d  = count_q;
    seen_d   = seen_q;
    unique case (s_axis_tuser)
      FUNC_TICK: begin
        if (count_inc >= timeout_ticks_q) begin
          // timed out: clip the counter, stop the motors only once
          count_d = timeout_ticks_q;
          if (!seen_q) begin
            target_d = fwd_zero;
          end
          seen_d = 1'b1;
        end else begin
          count_d = count_inc;
          seen_d  = 1'b0;
        end
        for (int ch = 0; ch < MotorChannels; ch++) begin
          actual_d[ch] = slew(actual_q[ch], target_d[ch], slew_step_q, max_pwm_q);
        end
      end
      FUNC_SET: begin
        count_d            = '0;
        target_d[CH_RIGHT] = speed_to_target(s_axis_tdata[15:0], right_fwd_q, max_pwm_q);
        target_d[CH_LEFT]  = speed_to_target(s_axis_tdata[31:16], left_fwd_q, max_pwm_q);
      end
      FUNC_PING: begin
        count_d = '0;
      end
      default: ;  // unused code: state holds, result still reported
    endcase
  end

  // result from the state after this input; the plus side drives when dir is 1
  always_comb begin
    result        = '0;
    result[7:0]   = actual_d[CH_LEFT].dir  ? actual_d[CH_LEFT].pwm  : '0;
    result[15:8]  = actual_d[CH_LEFT].dir  ? '0 : actual_d[CH_LEFT].pwm;
    result[23:16] = actual_d[CH_RIGHT].dir ? actual_d[CH_RIGHT].pwm : '0;
    result[31:24] = actual_d[CH_RIGHT].dir ? '0 : actual_d[CH_RIGHT].pwm;
    result[32]    = seen_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int ch = 0; ch < MotorChannels; ch++) begin
        actual_q[ch] <= '0;
        target_q[ch] <= '0;
      end
      count_q <= '0;
      seen_q  <= 1'b0;
    end else if (in_fire) begin
      actual_q <= actual_d;
      target_q <= target_d;
      count_q  <= count_d;
      seen_q   <= seen_d;
    end
  end

  // output register with a skid stage behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_fire) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end
      end else if (in_fire) begin
        if (!out_valid_q || out_fire) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_data_q <= skid_data_q;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_data_q <= result;
      end else begin
        skid_data_q <= result;
      end
    end
  end

  // the skid only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds data while output register is empty");

  // an input taken while the receiver stalls must land in the skid
  a_stall_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && out_valid_q && !m_axis_tready) |=> skid_valid_q)
    else $error("input taken during stall was not parked");

  // a bridge never drives both sides at once
  a_left_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q[7:0] == '0 || out_data_q[15:8] == '0))
    else $error("left bridge drives plus and minus together");

  a_right_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q[23:16] == '0 || out_data_q[31:24] == '0))
    else $error("right bridge drives plus and minus together");

endmodule
